// ----- hw/rtl/nearest_palette_color_core_defines.svh -----
// ---------------------------------------------------------------------------
// Nearest palette color core assertion macros
// Concurrent assertion helpers shared by the RTL of the palette search block.
// ---------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_CORE_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Antecedent implies consequent in the same cycle.
`define NPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("nearest palette color core: assertion failed");

// Antecedent implies consequent in the next cycle.
`define NPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("nearest palette color core: assertion failed");

`else

`define NPC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define NPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/npc_pkg.sv -----
// ---------------------------------------------------------------------------
// Nearest palette color package
// Types and constants shared by the nearest palette color search block.
// ---------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

	// Default palette depth.
	localparam int unsigned NPC_ENTRIES = 64;

	// Width of the entries-in-use register.
	localparam int unsigned CFG_W = 7;

	// Reset value of the entries-in-use register.
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// Transaction kinds.
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [5:0] entry_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} npc_in_t;

	typedef struct packed {
		logic [5:0]  match_index;
		logic [7:0]  match_red;
		logic [7:0]  match_green;
		logic [7:0]  match_blue;
		logic [17:0] match_distance_sq;
	} npc_out_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} npc_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nearest_palette_color_core.sv -----
// ---------------------------------------------------------------------------
// Nearest palette color core
// Palette store with a sequential nearest-color search by squared distance.
// ---------------------------------------------------------------------------
// The block holds a palette of ENTRIES 24-bit RGB colors in one synchronous
// RAM. A load transaction writes one entry and returns no result. A query
// transaction walks the palette from entry zero, reading one entry per cycle
// from the RAM port, and returns the entry with the least squared distance,
// lowest index on ties. A query over N entries in use makes N RAM reads,
// then passes through the registered read data and the registered distance,
// and hands the winner to the output register once that register is free or
// being read. The result waits in that register, so the next transaction is
// taken while it is still unread. After reset the block zeroes the RAM, one
// entry per cycle, and accepts no transaction until that pass ends;
// configuration writes are taken at any time. The entries_in_use register
// reads zero as one and saturates at ENTRIES.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nearest_palette_color_core_defines.svh"

module nearest_palette_color_core #(
	parameter int unsigned ENTRIES = npc_pkg::NPC_ENTRIES
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,

	input  wire logic                       cfg_wr_en,
	input  wire logic [npc_pkg::CFG_W-1:0]  cfg_wr_data,

	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire npc_pkg::npc_in_t           in_data,

	output logic                            out_valid,
	input  wire logic                       out_ready,
	output npc_pkg::npc_out_t               out_data
);

	import npc_pkg::*;

	// Address width of the palette RAM; a single-entry palette still gets one bit.
	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

	// Control state.
	npc_state_t state_q, state_d;
	logic [CFG_W-1:0] cfg_q;
	logic [AW-1:0] clr_addr_q;
	logic [AW-1:0] rd_addr_q;
	logic [AW-1:0] last_addr_q;
	logic rd_done_q;

	// FSM outputs.
	logic clearing;
	logic rd_en;
	logic out_load;

	// Query color held for the whole search.
	logic [7:0] qry_red_q, qry_green_q, qry_blue_q;

	// Palette RAM.
	logic [23:0] palette_mem [ENTRIES];
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [23:0] mem_wdata;

	// Stage 1: RAM read data.
	logic valid_s1, first_s1, last_s1;
	logic [AW-1:0] idx_s1;
	logic [23:0] rgb_s1;

	// Stage 2: distance.
	logic valid_s2, first_s2, last_s2;
	logic [AW-1:0] idx_s2;
	logic [23:0] rgb_s2;
	logic [17:0] dist_s2;

	// Running best.
	logic [AW-1:0] best_idx_q;
	logic [23:0] best_rgb_q;
	logic [17:0] best_dist_q;
	logic take;

	// Output register.
	logic out_valid_q;
	npc_out_t out_q;

	logic in_fire;
	logic load_fire;
	logic query_fire;
	logic [AW-1:0] query_last;
	logic [7:0] diff_r, diff_g, diff_b;
	logic [15:0] sq_r, sq_g, sq_b;
	logic [17:0] dist_s1;

	assign in_fire    = in_valid && in_ready;
	assign load_fire  = in_fire && (in_data.mode == MODE_LOAD);
	assign query_fire = in_fire && (in_data.mode == MODE_QUERY);

	// Last entry a query searches, with zero read as one and saturation at the
	// palette depth.
	always_comb begin
		if (cfg_q == '0) begin
			query_last = '0;
		end else if (32'(cfg_q) > ENTRIES) begin
			query_last = LAST_ADDR;
		end else begin
			query_last = AW'(32'(cfg_q) - 32'd1);
		end
	end

	// -----------------------------------------------------------------------
	// Sequencer
	// -----------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (query_fire) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (valid_s2 && last_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		clearing = 1'b0;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				clearing = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_SEARCH: begin
				rd_en = !rd_done_q;
			end
			ST_DONE: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
				clearing = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cfg_q       <= CFG_RESET;
			clr_addr_q  <= '0;
			rd_addr_q   <= '0;
			last_addr_q <= '0;
			rd_done_q   <= 1'b1;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (clearing) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (query_fire) begin
				rd_addr_q   <= '0;
				last_addr_q <= query_last;
				rd_done_q   <= 1'b0;
			end else if (rd_en) begin
				if (rd_addr_q == last_addr_q) begin
					rd_done_q <= 1'b1;
				end else begin
					rd_addr_q <= rd_addr_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_fire) begin
			qry_red_q   <= in_data.red;
			qry_green_q <= in_data.green;
			qry_blue_q  <= in_data.blue;
		end
	end

	// -----------------------------------------------------------------------
	// Palette RAM: one write port shared by the clearing pass and loads, one
	// registered read port for the search. Loads only happen while idle and
	// reads only while searching, so the two never touch the same cycle.
	// -----------------------------------------------------------------------
	always_comb begin
		if (clearing) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			// Indices past the end of the palette are dropped.
			mem_we    = load_fire && (32'(in_data.entry_index) < ENTRIES);
			mem_waddr = AW'(in_data.entry_index);
			mem_wdata = {in_data.red, in_data.green, in_data.blue};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			palette_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rgb_s1 <= palette_mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1   <= rd_addr_q;
			first_s1 <= (rd_addr_q == '0);
			last_s1  <= (rd_addr_q == last_addr_q);
		end
	end

	// Squared distance of the entry just read.
	always_comb begin
		diff_r = (qry_red_q > rgb_s1[23:16]) ? (qry_red_q - rgb_s1[23:16])
			: (rgb_s1[23:16] - qry_red_q);
		diff_g = (qry_green_q > rgb_s1[15:8]) ? (qry_green_q - rgb_s1[15:8])
			: (rgb_s1[15:8] - qry_green_q);
		diff_b = (qry_blue_q > rgb_s1[7:0]) ? (qry_blue_q - rgb_s1[7:0])
			: (rgb_s1[7:0] - qry_blue_q);
		sq_r = diff_r * diff_r;
		sq_g = diff_g * diff_g;
		sq_b = diff_b * diff_b;
		dist_s1 = 18'(sq_r) + 18'(sq_g) + 18'(sq_b);
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			idx_s2   <= idx_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			rgb_s2   <= rgb_s1;
			dist_s2  <= dist_s1;
		end
	end

	// Strict compare keeps the lowest index on a tie; entry zero always seeds
	// the running best.
	assign take = valid_s2 && (first_s2 || (dist_s2 < best_dist_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= idx_s2;
			best_rgb_q  <= rgb_s2;
			best_dist_q <= dist_s2;
		end
	end

	// -----------------------------------------------------------------------
	// Output register
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.match_index       <= 6'(best_idx_q);
			out_q.match_red         <= best_rgb_q[23:16];
			out_q.match_green       <= best_rgb_q[15:8];
			out_q.match_blue        <= best_rgb_q[7:0];
			out_q.match_distance_sq <= best_dist_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// -----------------------------------------------------------------------
	// Assertions
	// -----------------------------------------------------------------------
	// The last distance of a search moves the sequencer to hand-off.
	`NPC_ASSERT_NEXT(a_last_to_done, clk, arst_n, valid_s2 && last_s2, state_q == ST_DONE)
	// The read pointer never runs past the last entry of the search.
	`NPC_ASSERT_SAME(a_rd_in_range, clk, arst_n, rd_en, rd_addr_q <= last_addr_q)
	// The pipeline is drained when the winner is handed to the output.
	`NPC_ASSERT_SAME(a_drained, clk, arst_n, state_q == ST_DONE, !valid_s1 && !valid_s2 && !rd_en)

endmodule

`default_nettype wire

// ----- sim/nearest_palette_color_core_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Nearest palette color checker
// Watches both channels and the entries_in_use register, keeps its own copy of
// the palette and scores every returned match against an exact search.
// ---------------------------------------------------------------------------

module nearest_palette_color_core_checker #(
	parameter int unsigned ENTRIES = npc_pkg::NPC_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [npc_pkg::CFG_W-1:0]     cfg_wr_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  npc_pkg::npc_in_t              in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  npc_pkg::npc_out_t             out_data,
	output int                            fail_count,
	output int                            pending
);
	import npc_pkg::*;

	logic [23:0]          shade [ENTRIES];
	logic [CFG_W-1:0]     search_len;
	npc_out_t             expected_matches [$];
	npc_out_t             want;
	int                   mismatches;

	function automatic int unsigned sq_gap(logic [7:0] a, logic [7:0] b);
		int d;
		d = int'(a) - int'(b);
		return d * d;
	endfunction

	// Exact squared distance over the entries in use; strict less-than keeps
	// the lowest index on ties.
	function automatic npc_out_t nearest_entry(npc_in_t q);
		int unsigned span;
		int unsigned best_i;
		int unsigned best_d;
		int unsigned d;
		npc_out_t m;
		span = 32'(search_len);
		if (span == 0)
			span = 1;
		if (span > ENTRIES)
			span = ENTRIES;
		best_i = 0;
		best_d = 32'hFFFF_FFFF;
		for (int unsigned i = 0; i < span; i++) begin
			d = sq_gap(q.red, shade[i][23:16]) + sq_gap(q.green, shade[i][15:8])
				+ sq_gap(q.blue, shade[i][7:0]);
			if (d < best_d) begin
				best_d = d;
				best_i = i;
			end
		end
		m.match_index       = best_i[5:0];
		m.match_red         = shade[best_i][23:16];
		m.match_green       = shade[best_i][15:8];
		m.match_blue        = shade[best_i][7:0];
		m.match_distance_sq = best_d[17:0];
		return m;
	endfunction

	function automatic void check_field(string name, logic [17:0] want_v, logic [17:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shade[i])
				shade[i] = '0;
			search_len = CFG_RESET;
			expected_matches.delete();
			mismatches = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_wr_en)
				search_len = cfg_wr_data;
			if (in_valid && in_ready) begin
				if (in_data.mode == MODE_LOAD) begin
					if (in_data.entry_index < ENTRIES)
						shade[in_data.entry_index] = {in_data.red, in_data.green, in_data.blue};
				end else begin
					expected_matches.push_back(nearest_entry(in_data));
				end
			end
			if (out_valid && out_ready) begin
				if (expected_matches.size() == 0) begin
					$error("result with no query waiting: match_index %0d", out_data.match_index);
					mismatches++;
				end else begin
					want = expected_matches.pop_front();
					check_field("match_index", 18'(want.match_index),
						18'(out_data.match_index));
					check_field("match_red", 18'(want.match_red), 18'(out_data.match_red));
					check_field("match_green", 18'(want.match_green),
						18'(out_data.match_green));
					check_field("match_blue", 18'(want.match_blue), 18'(out_data.match_blue));
					check_field("match_distance_sq", want.match_distance_sq,
						out_data.match_distance_sq);
				end
			end
			fail_count <= mismatches;
			pending    <= expected_matches.size();
		end
	end

endmodule

// ----- sim/nearest_palette_color_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Nearest palette color core testbench
// Loads palettes and runs color queries under random idling on both channels,
// across several entries_in_use settings, while the checker scores results.
// ---------------------------------------------------------------------------

module nearest_palette_color_core_tb;
	import npc_pkg::*;

	localparam int unsigned ENTRIES = NPC_ENTRIES;

	// Slowest legal stretch without any transaction is the clearing pass after
	// reset, or a full-palette query with both sides at their longest pause.
	// The limit is that taken several times over.
	localparam int unsigned IDLE_LIMIT = 1000;

	// Settling time before a register write or the verdict: a load can still
	// be in flight after the last result, and a query searches the whole palette.
	localparam int unsigned SETTLE = ENTRIES + 8;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [CFG_W-1:0]   cfg_wr_data;
	logic               in_valid;
	logic               in_ready;
	npc_in_t            in_data;
	logic               out_valid;
	logic               out_ready;
	npc_out_t           out_data;
	int                 fail_count;
	int                 pending;

	// When set, neither side inserts any pause, so back-to-back traffic is
	// covered as well as the gapped kind.
	bit                 steady;

	// Stimulus-side record of what was written, used only to aim queries and
	// duplicate loads at colors already in the palette.
	logic [23:0]        loaded [ENTRIES];
	int unsigned        active_len;

	nearest_palette_color_core #(
		.ENTRIES     (ENTRIES)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

	nearest_palette_color_core_checker #(
		.ENTRIES     (ENTRIES)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned pause_len();
		return steady ? 0 : $urandom_range(0, 12);
	endfunction

	// Colors are drawn from a coarse grid (which includes the extremes and
	// makes equal distances common), from entries already loaded (exact hits
	// and duplicate entries), or from the full range.
	function automatic logic [23:0] pick_color();
		logic [23:0] c;
		case ($urandom_range(0, 3))
			0: begin
				c = {8'($urandom_range(0, 3) * 85), 8'($urandom_range(0, 3) * 85),
					8'($urandom_range(0, 3) * 85)};
			end
			1: begin
				c = loaded[$urandom_range(0, ENTRIES - 1)];
			end
			default: begin
				c = 24'($urandom());
			end
		endcase
		return c;
	endfunction

	// Presents one transaction after a random pause and holds it until the
	// block takes it. The task returns on the accepting edge, so the caller
	// drives the next transaction, or drops valid, in that same time step.
	task automatic send_color(input logic mode, input logic [5:0] idx, input logic [23:0] rgb);
		int unsigned gap;
		gap = pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {mode, idx, rgb};
		do @(posedge clk); while (in_ready !== 1'b1);
		if (mode == MODE_LOAD)
			loaded[idx] = rgb;
	endtask

	// Loads lean toward the entries that the current setting searches so that
	// the search sees fresh data; the rest land anywhere in the store.
	task automatic send_random();
		int unsigned span;
		logic [5:0]  idx;
		logic        mode;
		span = (active_len == 0) ? 1 : (active_len > ENTRIES) ? ENTRIES : active_len;
		mode = ($urandom_range(0, 99) < 55) ? MODE_QUERY : MODE_LOAD;
		if (mode == MODE_LOAD && $urandom_range(0, 1))
			idx = 6'($urandom_range(0, span - 1));
		else
			idx = 6'($urandom_range(0, ENTRIES - 1));
		send_color(mode, idx, pick_color());
	endtask

	// Stops sending and waits until every query has been answered, then lets
	// the block settle.
	task automatic quiesce();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_entries(input int unsigned value);
		quiesce();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= CFG_W'(value);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		active_len = value;
	endtask

	// Result side: one random pause before each result, then ready stays high
	// until a result is taken.
	initial begin : result_sink
		int unsigned stall;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			stall = pause_len();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Watchdog: ends the run if no transaction moves on either channel for
	// too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT)
				break;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int unsigned span;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		steady      = 1'b0;
		active_len  = 32'(CFG_RESET);
		foreach (loaded[i])
			loaded[i] = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, at the reset setting of 64 entries in use. The first
		// query sees a palette that is all zero after reset: white gives the
		// largest possible distance at entry 0.
		send_color(MODE_QUERY, 6'd63, 24'hFFFFFF);

		// Corner colors, with index bit patterns that toggle every bit.
		send_color(MODE_LOAD, 6'd63, 24'hFFFFFF);
		send_color(MODE_LOAD, 6'd1, 24'hFF0000);
		send_color(MODE_LOAD, 6'd2, 24'h00FF00);
		send_color(MODE_LOAD, 6'd3, 24'h0000FF);
		send_color(MODE_LOAD, 6'd42, 24'hAA55AA);
		send_color(MODE_LOAD, 6'd21, 24'h55AA55);

		// Exact hits at the top entry and at entry 0; entry_index on a query
		// must be ignored.
		send_color(MODE_QUERY, 6'd0, 24'hFFFFFF);
		send_color(MODE_QUERY, 6'd42, 24'h000000);

		// Two identical entries: the lower index must win the tie at zero.
		send_color(MODE_LOAD, 6'd4, 24'h808080);
		send_color(MODE_LOAD, 6'd5, 24'h808080);
		send_color(MODE_QUERY, 6'd21, 24'h808080);

		// Two different entries at the same nonzero distance from the query.
		send_color(MODE_LOAD, 6'd10, 24'h640000);
		send_color(MODE_LOAD, 6'd11, 24'h780000);
		send_color(MODE_QUERY, 6'd63, 24'h6E0000);
		send_color(MODE_QUERY, 6'd0, 24'hFA0503);

		// A setting of zero searches entry 0 alone, the same as a setting of one.
		set_entries(0);
		send_color(MODE_QUERY, 6'd5, 24'hC8C8C8);
		set_entries(1);
		send_color(MODE_QUERY, 6'd5, 24'hC8C8C8);

		// Settings above the store size saturate to the whole palette.
		set_entries(127);
		send_color(MODE_QUERY, 6'd1, 24'hFFFFFF);
		send_color(MODE_QUERY, 6'd2, 24'h00FF00);
		set_entries(65);
		send_color(MODE_QUERY, 6'd3, 24'h55AA55);

		// Random part: nine phases of fifty transactions, each under its own
		// setting. Every register write waits for all results first, so the
		// sender pauses until the result queue is empty at each boundary.
		for (int p = 0; p < 9; p++) begin
			case (p)
				0: span = 64;
				1: span = 2;
				2: span = 127;
				3: span = $urandom_range(3, 62);
				4: span = 1;
				5: span = $urandom_range(65, 126);
				6: span = 0;
				7: span = 63;
				default: span = 64;
			endcase
			set_entries(span);
			steady = (p == 0 || p == 5);
			repeat (50) send_random();
		end

		steady = 1'b0;
		quiesce();
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
